[design/pqra_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the packet queue redline admission block
// no dependencies

package pqra_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int QBYTES_MAX      = 4194303;
   localparam int BYTE_LIMIT_RST  = 1024 * 1024;

   localparam int OP_W      = 2;
   localparam int HANDLE_W  = 16;
   localparam int SIZE_W    = 16;
   localparam int TIME_W    = 32;
   localparam int KIND_W    = 3;
   localparam int QBYTES_W  = 22;
   localparam int QCOUNT_W  = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 24;
   localparam int BLIM_W    = 24;
   localparam int CLIM_W    = 11;
   localparam int ALIM_W    = 16;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_RELEASED = 3'd0,
      KIND_ACCEPTED = 3'd1,
      KIND_REJECTED = 3'd2,
      KIND_POPPED   = 3'd3,
      KIND_IGNORED  = 3'd4,
      KIND_HEAD     = 3'd5,
      KIND_CLEARED  = 3'd6
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DROP_OLDEST = 2'd0,
      REG_BYTE_LIMIT  = 2'd1,
      REG_COUNT_LIMIT = 2'd2,
      REG_AGE_LIMIT   = 2'd3
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_AGE,
      ST_BYTES,
      ST_RELEASE,
      ST_EVICT,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   bytes;
      logic [TIME_W-1:0]   arrival;
   } desc_type;

   typedef struct packed {
      logic              drop_oldest;
      logic [BLIM_W-1:0] byte_limit;
      logic [CLIM_W-1:0] count_limit;
      logic [ALIM_W-1:0] age_limit;
   } cfg_type;

   // shared unit: ((a + b + cin) mod 2^32) > c
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        cin;
      logic [31:0] c;
   } cmp_req_type;

endpackage

[design/pqra_ring.sv]
`timescale 1ns / 1ps
// descriptor ring memory, one write port and one registered read port
// depends on pqra_pkg

module pqra_ring
   import pqra_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  desc_type         wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output desc_type         rd_data
);

   desc_type mem [QUEUE_DEPTH];
   desc_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

[design/pqra_addcmp.sv]
`timescale 1ns / 1ps
// shared add and compare unit used for the age test and the byte limit test
// depends on pqra_pkg

module pqra_addcmp
   import pqra_pkg::*;
(
   input  cmp_req_type req,
   output logic        gt
);

   logic [31:0] sum;

   assign sum = req.a + req.b + 32'(req.cin);
   assign gt  = sum > req.c;

endmodule

[design/pqra_ctrl.sv]
`timescale 1ns / 1ps
// sequencer, queue pointers and counters, result register
// depends on pqra_pkg, pqra_ring and pqra_addcmp

module pqra_ctrl
   import pqra_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_op,
   input  logic [HANDLE_W-1:0] req_packet_handle,
   input  logic [SIZE_W-1:0]   req_payload_bytes,
   input  logic [TIME_W-1:0]   req_now_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_kind,
   output logic [HANDLE_W-1:0] rsp_handle,
   output logic                rsp_head_valid,
   output logic [QBYTES_W-1:0] rsp_queued_bytes,
   output logic [QCOUNT_W-1:0] rsp_queued_count,
   output logic                rsp_last
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int TB_W  = SIZE_W + CNT_W;

   state_type state_ff, state_in;

   op_type              op_ff;
   logic [HANDLE_W-1:0] h_ff;
   logic [SIZE_W-1:0]   sz_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                reject_ff, reject_in;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [TB_W-1:0]  total_ff, total_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                hv_ff;
   logic [QBYTES_W-1:0] qbytes_ff;
   logic [QCOUNT_W-1:0] qcount_ff;
   logic                last_ff, last_in;

   desc_type    rd_desc;
   desc_type    wr_desc;
   cmp_req_type cmp_req;
   logic        cmp_gt;

   logic out_free, nonempty, full, pop_hit;
   logic take, emit, remove, append, clear;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign nonempty = count_ff != '0;
   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_hit  = nonempty && (rd_desc.handle == h_ff);
   assign wr_desc  = '{handle: h_ff, bytes: sz_ff, arrival: now_ff};

   pqra_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (append),
      .wr_addr (tail_ff),
      .wr_data (wr_desc),
      .rd_addr (head_ff),
      .rd_data (rd_desc)
   );

   pqra_addcmp u_cmp (
      .req (cmp_req),
      .gt  (cmp_gt)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (op_type'(req_op) == OP_CLEAR) ? ST_FINAL : ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (op_ff == OP_PUSH) begin
               if (nonempty && (cfg.drop_oldest || cfg.age_limit != '0)) begin
                  state_in = ST_AGE;
               end else begin
                  state_in = ST_BYTES;
               end
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_AGE: begin
            state_in = cmp_gt ? ST_RELEASE : ST_BYTES;
         end
         ST_BYTES: begin
            priority if (cfg.drop_oldest && nonempty && cmp_gt) begin
               state_in = ST_RELEASE;
            end else if (cfg.drop_oldest && full) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_RELEASE: begin
            if (out_free) state_in = ST_FETCH;
         end
         ST_EVICT: begin
            if (out_free) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      take    = 1'b0;
      emit    = 1'b0;
      remove  = 1'b0;
      append  = 1'b0;
      clear   = 1'b0;
      cmp_req = '{a: 32'(total_ff), b: 32'(sz_ff), cin: 1'b0, c: 32'(cfg.byte_limit)};
      kind_in   = KIND_RELEASED;
      handle_in = rd_desc.handle;
      last_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            take = req_valid;
         end
         ST_AGE: begin
            cmp_req = '{a: now_ff, b: ~rd_desc.arrival, cin: 1'b1, c: 32'(cfg.age_limit)};
         end
         ST_RELEASE, ST_EVICT: begin
            emit   = out_free;
            remove = out_free;
         end
         ST_FINAL: begin
            emit    = out_free;
            last_in = 1'b1;
            unique case (op_ff)
               OP_PUSH: begin
                  append    = out_free && !reject_ff;
                  kind_in   = reject_ff ? KIND_REJECTED : KIND_ACCEPTED;
                  handle_in = h_ff;
               end
               OP_POP: begin
                  remove    = out_free && pop_hit;
                  kind_in   = pop_hit ? KIND_POPPED : KIND_IGNORED;
                  handle_in = pop_hit ? rd_desc.handle : h_ff;
               end
               OP_PEEK: begin
                  kind_in   = KIND_HEAD;
                  handle_in = nonempty ? rd_desc.handle : '0;
               end
               OP_CLEAR: begin
                  clear     = out_free;
                  kind_in   = KIND_CLEARED;
                  handle_in = '0;
               end
               default: kind_in = KIND_CLEARED;
            endcase
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   // reject decision
   always_comb begin
      reject_in = reject_ff;
      if (state_ff == ST_BYTES) begin
         reject_in = !cfg.drop_oldest &&
                     ((nonempty && (cmp_gt || (cfg.count_limit != '0 &&
                       CLIM_W'(count_ff) >= cfg.count_limit))) || full);
      end
   end

   // queue bookkeeping
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      total_in = total_ff;
      priority if (clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
         total_in = '0;
      end else if (remove) begin
         head_in  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
         total_in = total_ff - TB_W'(rd_desc.bytes);
      end else if (append) begin
         tail_in  = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
         total_in = total_ff + TB_W'(sz_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         reject_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         reject_ff    <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff  <= op_type'(req_op);
         h_ff   <= req_packet_handle;
         sz_ff  <= req_payload_bytes;
         now_ff <= req_now_ms;
      end
      if (emit) begin
         kind_ff   <= kind_in;
         handle_ff <= handle_in;
         last_ff   <= last_in;
         hv_ff     <= count_in != '0;
         qbytes_ff <= (32'(total_in) > 32'(QBYTES_MAX)) ? QBYTES_W'(QBYTES_MAX)
                                                        : QBYTES_W'(total_in);
         qcount_ff <= QCOUNT_W'(count_in);
      end
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_handle       = handle_ff;
   assign rsp_head_valid   = hv_ff;
   assign rsp_queued_bytes = qbytes_ff;
   assign rsp_queued_count = qcount_ff;
   assign rsp_last         = last_ff;

endmodule

[design/packet_queue_redline_admission.sv]
`timescale 1ns / 1ps
// top level of the packet queue redline admission block: config registers and core
// depends on pqra_pkg and pqra_ctrl

// One request at a time. A clear goes straight to its result; a pop or peek first reads
// the head descriptor, and a push reads the head, tests the head age when it is tested
// (age limit set or drop-oldest mode, queue not empty), then tests the byte limit. Every
// head entry released on the way repeats the head read and the tests, and the eviction
// from a full store in drop-oldest mode adds one more result. The sequence is shaped by
// the registered read of the descriptor ring and by the single add-compare unit, which
// runs the age test and the byte limit test in separate cycles. Results leave through an
// output register, so a stalled result only holds up the next step that emits a result.
// The ring needs no clearing pass after reset.
module packet_queue_redline_admission
   import pqra_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OP_W-1:0]      req_op,
   input  logic [HANDLE_W-1:0]  req_packet_handle,
   input  logic [SIZE_W-1:0]    req_payload_bytes,
   input  logic [TIME_W-1:0]    req_now_ms,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_kind,
   output logic [HANDLE_W-1:0]  rsp_handle,
   output logic                 rsp_head_valid,
   output logic [QBYTES_W-1:0]  rsp_queued_bytes,
   output logic [QCOUNT_W-1:0]  rsp_queued_count,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (reg_idx_type'(csr_index))
            REG_DROP_OLDEST: cfg_in.drop_oldest = csr_wdata[0];
            REG_BYTE_LIMIT:  cfg_in.byte_limit  = csr_wdata[BLIM_W-1:0];
            REG_COUNT_LIMIT: cfg_in.count_limit = csr_wdata[CLIM_W-1:0];
            REG_AGE_LIMIT:   cfg_in.age_limit   = csr_wdata[ALIM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{drop_oldest: 1'b0, byte_limit: BLIM_W'(BYTE_LIMIT_RST),
                     count_limit: '0, age_limit: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pqra_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_packet_handle (req_packet_handle),
      .req_payload_bytes (req_payload_bytes),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_handle        (rsp_handle),
      .rsp_head_valid    (rsp_head_valid),
      .rsp_queued_bytes  (rsp_queued_bytes),
      .rsp_queued_count  (rsp_queued_count),
      .rsp_last          (rsp_last)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queued_count <= QCOUNT_W'(QUEUE_DEPTH))
      else $error("queued count beyond depth");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_head_valid == (rsp_queued_count != '0))
      else $error("head valid disagrees with count");

   a_release_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_RELEASED)
      else $error("non-final result is not a release");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

endmodule

[tb/packet_queue_redline_admission_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the packet queue redline admission block
// depends on pqra_pkg and packet_queue_redline_admission; holds its own queue predictor

module packet_queue_redline_admission_tb;
   import pqra_pkg::*;

   localparam int          DEPTH       = QUEUE_DEPTH_DEF;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned PHASES      = 8;
   localparam int unsigned PHASE_ITEMS = 44;
   localparam int unsigned AW_DEPTH    = 64;
   localparam int unsigned DIR_MAX     = 32;

   typedef struct packed {
      kind_type            kind;
      logic [HANDLE_W-1:0] handle;
      logic                head_valid;
      logic [QBYTES_W-1:0] qbytes;
      logic [QCOUNT_W-1:0] qcount;
      logic                last;
   } q_status_type;

   typedef struct packed {
      bit                  is_cfg;
      cfg_type             cfg;
      op_type              op;
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   bytes;
      logic [TIME_W-1:0]   now;
      bit                  has_exp;
      q_status_type        exp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op = OP_PUSH;
   logic [HANDLE_W-1:0]  req_packet_handle = '0;
   logic [SIZE_W-1:0]    req_payload_bytes = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [HANDLE_W-1:0]  rsp_handle;
   logic                 rsp_head_valid;
   logic [QBYTES_W-1:0]  rsp_queued_bytes;
   logic [QCOUNT_W-1:0]  rsp_queued_count;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_DROP_OLDEST;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // predictor state
   desc_type     ring [DEPTH];
   int unsigned  head_ptr = 0;
   int unsigned  tail_ptr = 0;
   int unsigned  q_count = 0;
   int unsigned  q_total = 0;
   cfg_type      cfg_now;
   q_status_type awaited [AW_DEPTH];
   int unsigned  aw_wr = 0;
   int unsigned  aw_rd = 0;
   q_status_type want;

   stim_row_type dir_tab [DIR_MAX];
   int unsigned  dir_cnt = 0;

   bit          calm = 1'b0;
   bit          req_held = 1'b0;
   int unsigned tx_gap = 0;
   int          fail_count = 0;
   logic [TIME_W-1:0] clk_ms;

   packet_queue_redline_admission i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_packet_handle(req_packet_handle),
      .req_payload_bytes(req_payload_bytes),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_handle       (rsp_handle),
      .rsp_head_valid   (rsp_head_valid),
      .rsp_queued_bytes (rsp_queued_bytes),
      .rsp_queued_count (rsp_queued_count),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned draw_gap();
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic bit head_expired(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      age = now - ring[head_ptr].arrival;
      return age > cfg_now.age_limit;
   endfunction

   task automatic note_status(q_status_type s);
      awaited[aw_wr % AW_DEPTH] = s;
      aw_wr = aw_wr + 1;
   endtask

   task automatic add_row(stim_row_type r);
      dir_tab[dir_cnt] = r;
      dir_cnt = dir_cnt + 1;
   endtask

   task automatic post_status(kind_type k, logic [HANDLE_W-1:0] h, logic last);
      q_status_type s;
      s.kind       = k;
      s.handle     = h;
      s.head_valid = (q_count > 0);
      s.qbytes     = (q_total > QBYTES_MAX) ? QBYTES_W'(QBYTES_MAX) : QBYTES_W'(q_total);
      s.qcount     = QCOUNT_W'(q_count);
      s.last       = last;
      note_status(s);
   endtask

   task automatic drop_head(kind_type k, logic last);
      desc_type d;
      d = ring[head_ptr];
      q_count--;
      q_total -= d.bytes;
      head_ptr = (head_ptr + 1) % DEPTH;
      post_status(k, d.handle, last);
   endtask

   task automatic apply_queue_op(op_type op, logic [HANDLE_W-1:0] h,
                                 logic [SIZE_W-1:0] sz, logic [TIME_W-1:0] now);
      bit reject;
      case (op)
         OP_PUSH: begin
            if (cfg_now.drop_oldest) begin
               while (q_count > 0 &&
                      (head_expired(now) || q_total + sz > cfg_now.byte_limit))
                  drop_head(KIND_RELEASED, 1'b0);
               if (q_count >= DEPTH) drop_head(KIND_RELEASED, 1'b0);
               reject = 1'b0;
            end else begin
               while (q_count > 0 && cfg_now.age_limit != 0 && head_expired(now))
                  drop_head(KIND_RELEASED, 1'b0);
               reject = (q_count > 0 && (q_total + sz > cfg_now.byte_limit ||
                         (cfg_now.count_limit != 0 && q_count >= cfg_now.count_limit)))
                        || q_count >= DEPTH;
            end
            if (reject) begin
               post_status(KIND_REJECTED, h, 1'b1);
            end else begin
               ring[tail_ptr] = {h, sz, now};
               tail_ptr = (tail_ptr + 1) % DEPTH;
               q_count++;
               q_total += sz;
               post_status(KIND_ACCEPTED, h, 1'b1);
            end
         end
         OP_POP: begin
            if (q_count > 0 && ring[head_ptr].handle == h) drop_head(KIND_POPPED, 1'b1);
            else post_status(KIND_IGNORED, h, 1'b1);
         end
         OP_PEEK: begin
            post_status(KIND_HEAD, (q_count > 0) ? ring[head_ptr].handle : '0, 1'b1);
         end
         default: begin
            head_ptr = 0;
            tail_ptr = 0;
            q_count  = 0;
            q_total  = 0;
            post_status(KIND_CLEARED, '0, 1'b1);
         end
      endcase
   endtask

   task automatic send_item(op_type op, logic [HANDLE_W-1:0] h,
                            logic [SIZE_W-1:0] b, logic [TIME_W-1:0] now);
      repeat (tx_gap) @(posedge clock);
      req_op            <= op;
      req_packet_handle <= h;
      req_payload_bytes <= b;
      req_now_ms        <= now;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
      apply_queue_op(op, h, b, now);
      tx_gap   = draw_gap();
      req_held = (tx_gap == 0);
      if (!req_held) req_valid <= 1'b0;
   endtask

   task automatic drain_queue();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      while (aw_wr != aw_rd) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_put(reg_idx_type idx, logic [CSR_DAT_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_cfg(cfg_type c);
      csr_put(REG_DROP_OLDEST, CSR_DAT_W'(c.drop_oldest));
      csr_put(REG_BYTE_LIMIT, CSR_DAT_W'(c.byte_limit));
      csr_put(REG_COUNT_LIMIT, CSR_DAT_W'(c.count_limit));
      csr_put(REG_AGE_LIMIT, CSR_DAT_W'(c.age_limit));
      csr_valid <= 1'b0;
      cfg_now = c;
   endtask

   task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   function automatic stim_row_type mk_item(op_type op, logic [HANDLE_W-1:0] h,
                                            logic [SIZE_W-1:0] b, logic [TIME_W-1:0] now);
      stim_row_type r;
      r        = '0;
      r.op     = op;
      r.handle = h;
      r.bytes  = b;
      r.now    = now;
      return r;
   endfunction

   function automatic stim_row_type mk_chk(op_type op, logic [HANDLE_W-1:0] h,
                                           logic [SIZE_W-1:0] b, logic [TIME_W-1:0] now,
                                           kind_type k, logic [HANDLE_W-1:0] eh, bit hv,
                                           int qb, int qc);
      stim_row_type r;
      r         = mk_item(op, h, b, now);
      r.has_exp = 1'b1;
      r.exp     = {k, eh, hv, QBYTES_W'(qb), QCOUNT_W'(qc), 1'b1};
      return r;
   endfunction

   function automatic stim_row_type mk_cfg(cfg_type c);
      stim_row_type r;
      r        = '0;
      r.is_cfg = 1'b1;
      r.cfg    = c;
      return r;
   endfunction

   // result sink with random stall per transfer
   initial begin : rsp_side
      int unsigned n;
      forever begin
         n = draw_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (aw_wr == aw_rd) begin
            $error("result with no expectation: kind %0d handle %0d", rsp_kind, rsp_handle);
            fail_count++;
         end else begin
            want  = awaited[aw_rd % AW_DEPTH];
            aw_rd = aw_rd + 1;
            compare_field("kind", want.kind, rsp_kind);
            compare_field("handle", want.handle, rsp_handle);
            compare_field("head_valid", want.head_valid, rsp_head_valid);
            compare_field("queued_bytes", want.qbytes, rsp_queued_bytes);
            compare_field("queued_count", want.qcount, rsp_queued_count);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int unsigned         phase, n, pick, push_w, pop_w, i;
      op_type              op;
      logic [HANDLE_W-1:0] h;
      logic [SIZE_W-1:0]   b;
      logic [TIME_W-1:0]   now;
      cfg_type             c;

      cfg_now = {1'b0, BLIM_W'(BYTE_LIMIT_RST), CLIM_W'(0), ALIM_W'(0)};
      clk_ms  = 32'hFFFF_F000;

      // reset defaults: no aging, no count limit
      add_row(mk_chk(OP_PEEK, 16'd0, 16'd0, 32'd0, KIND_HEAD, 16'd0, 0, 0, 0));
      add_row(mk_chk(OP_POP, 16'd5, 16'd0, 32'd0, KIND_IGNORED, 16'd5, 0, 0, 0));
      add_row(mk_chk(OP_PUSH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                     KIND_ACCEPTED, 16'hFFFF, 1, 65535, 1));
      add_row(mk_chk(OP_PUSH, 16'd0, 16'd0, 32'd0,
                     KIND_ACCEPTED, 16'd0, 1, 65535, 2));
      add_row(mk_chk(OP_PEEK, 16'h1234, 16'd0, 32'd0,
                     KIND_HEAD, 16'hFFFF, 1, 65535, 2));
      add_row(mk_chk(OP_POP, 16'd0, 16'd0, 32'd0,
                     KIND_IGNORED, 16'd0, 1, 65535, 2));
      add_row(mk_chk(OP_POP, 16'hFFFF, 16'd0, 32'd0,
                     KIND_POPPED, 16'hFFFF, 1, 0, 1));
      add_row(mk_chk(OP_CLEAR, 16'd0, 16'd0, 32'd0, KIND_CLEARED, 16'd0, 0, 0, 0));
      // minimum limits: empty queue still accepts
      add_row(mk_cfg({1'b0, 24'd1, 11'd1, 16'd0}));
      add_row(mk_chk(OP_PUSH, 16'd1, 16'd100, 32'd10,
                     KIND_ACCEPTED, 16'd1, 1, 100, 1));
      add_row(mk_chk(OP_PUSH, 16'd2, 16'd0, 32'd11,
                     KIND_REJECTED, 16'd2, 1, 100, 1));
      // maximum limits: age exactly at the limit, then one past it
      add_row(mk_cfg({1'b0, 24'hFF_FFFF, 11'd1024, 16'hFFFF}));
      add_row(mk_item(OP_PUSH, 16'd3, 16'd5, 32'd65545));
      add_row(mk_item(OP_PUSH, 16'd4, 16'd6, 32'd65546));
      add_row(mk_item(OP_PEEK, 16'd0, 16'd0, 32'd0));
      add_row(mk_chk(OP_CLEAR, 16'd0, 16'd0, 32'd0, KIND_CLEARED, 16'd0, 0, 0, 0));
      // age across the time wrap
      add_row(mk_cfg({1'b0, 24'(BYTE_LIMIT_RST), 11'd0, 16'd100}));
      add_row(mk_item(OP_PUSH, 16'd6, 16'd10, 32'hFFFF_FFF0));
      add_row(mk_item(OP_PUSH, 16'd7, 16'd10, 32'h0000_0050));
      add_row(mk_item(OP_PUSH, 16'd8, 16'd10, 32'h0000_0060));
      // drop oldest: zero age limit, then byte overflow eviction
      add_row(mk_cfg({1'b1, 24'd25, 11'd0, 16'd0}));
      add_row(mk_item(OP_PUSH, 16'd9, 16'd10, 32'h0000_0060));
      add_row(mk_item(OP_PUSH, 16'd10, 16'd20, 32'h0000_0060));
      add_row(mk_item(OP_POP, 16'd10, 16'd0, 32'h0000_0060));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < dir_cnt; i++) begin
         if (dir_tab[i].is_cfg) begin
            drain_queue();
            write_cfg(dir_tab[i].cfg);
         end else begin
            send_item(dir_tab[i].op, dir_tab[i].handle, dir_tab[i].bytes, dir_tab[i].now);
            if (dir_tab[i].has_exp)
               awaited[(aw_wr - 1) % AW_DEPTH] = dir_tab[i].exp;
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         drain_queue();
         case (phase)
            0: c = {1'b0, 24'hFF_FFFF, 11'd1024, 16'hFFFF};
            1: c = {1'b1, 24'hFF_FFFF, 11'd0, 16'hFFFF};
            2: c = {1'b1, 24'd1, 11'd0, 16'd0};
            3: c = {1'b0, 24'd1, 11'd1, 16'd0};
            default: begin
               c.drop_oldest = 1'($urandom_range(0, 1));
               case ($urandom_range(0, 3))
                  0: c.byte_limit = BLIM_W'($urandom_range(1, 4000));
                  1: c.byte_limit = BLIM_W'($urandom_range(4000, 200000));
                  2: c.byte_limit = 24'hFF_FFFF;
                  default: c.byte_limit = BLIM_W'($urandom_range(1, 24'hFF_FFFF));
               endcase
               case ($urandom_range(0, 3))
                  0: c.count_limit = 11'd0;
                  1: c.count_limit = CLIM_W'($urandom_range(1, 8));
                  2: c.count_limit = CLIM_W'($urandom_range(9, 40));
                  default: c.count_limit = CLIM_W'($urandom_range(0, 1024));
               endcase
               case ($urandom_range(0, 3))
                  0: c.age_limit = 16'd0;
                  1: c.age_limit = ALIM_W'($urandom_range(1, 300));
                  2: c.age_limit = 16'hFFFF;
                  default: c.age_limit = ALIM_W'($urandom_range(0, 65535));
               endcase
            end
         endcase
         write_cfg(c);
         calm = (phase > 1) && ($urandom_range(0, 3) == 0);
         // first two phases fill the store
         if (phase < 2) begin
            push_w = 90;
            pop_w  = 5;
         end else begin
            push_w = $urandom_range(35, 60);
            pop_w  = $urandom_range(15, 30);
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_w) op = OP_PUSH;
            else if (pick < push_w + pop_w) op = OP_POP;
            else if (pick < push_w + pop_w + 5) op = OP_PEEK;
            else op = OP_CLEAR;
            h = HANDLE_W'($urandom_range(0, 65535));
            if (op == OP_POP && q_count > 0 && $urandom_range(0, 4) != 0)
               h = ring[head_ptr].handle;
            b = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 65535))
                                            : SIZE_W'($urandom_range(0, 1500));
            clk_ms += TIME_W'($urandom_range(0, 40));
            now = (phase > 1 && $urandom_range(0, 19) == 0) ? TIME_W'($urandom()) : clk_ms;
            send_item(op, h, b, now);
         end
      end

      drain_queue();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
